// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the sign-magnitude ALU RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define SMH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== rtl/core/smh_pkg.sv =====
// Types and constants shared by the sign-magnitude hex ALU pipeline.
`timescale 1ns / 1ps

package smh_pkg;

	localparam int FUNC_W  = 4;
	localparam int MAG_W   = 32;
	localparam int SHIFT_W = 6;
	localparam int CNT_W   = 5;
	localparam int WIDE_W  = 64;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD = 4'd0,
		FN_SUB = 4'd1,
		FN_SHL = 4'd2,
		FN_SHR = 4'd3,
		FN_EQ  = 4'd4,
		FN_NE  = 4'd5,
		FN_GT  = 4'd6,
		FN_LT  = 4'd7,
		FN_GE  = 4'd8,
		FN_LE  = 4'd9,
		FN_ODD = 4'd10
	} smh_func_t;

	// Normalized operands, held in the first pipeline register.
	typedef struct packed {
		smh_func_t          func;
		logic               a_sign;
		logic [MAG_W-1:0]   a_mag;
		logic               b_sign;
		logic               b_nz;
		logic [MAG_W-1:0]   b_mag;
		logic [CNT_W-1:0]   shift_cnt;
	} smh_op_t;

	// Raw arithmetic results, held in the second pipeline register.
	typedef struct packed {
		smh_func_t          func;
		logic               a_sign;
		logic               b_sign;
		logic               b_nz;
		logic               a_odd;
		logic [MAG_W:0]     sum;
		logic               sum_ovf;
		logic [MAG_W:0]     diff_ab;
		logic [MAG_W-1:0]   diff_ba;
		logic               mag_eq;
		logic [WIDE_W-1:0]  shl;
		logic [MAG_W-1:0]   shr;
	} smh_exe_t;

endpackage

// ===== rtl/core/smh_norm.sv =====
// First stage: masks magnitudes to the digit width, fixes signs of zero, clamps the shift.
`timescale 1ns / 1ps

module smh_norm #(
	parameter int DIGITS = 8
) (
	input  logic [smh_pkg::FUNC_W-1:0]  func,
	input  logic                        a_sign,
	input  logic [smh_pkg::MAG_W-1:0]   a_mag,
	input  logic                        b_sign,
	input  logic [smh_pkg::MAG_W-1:0]   b_mag,
	input  logic [smh_pkg::SHIFT_W-1:0] shift_amount,
	output smh_pkg::smh_op_t            op
);
	import smh_pkg::*;

	localparam int NB = 4 * DIGITS;
	localparam logic [MAG_W-1:0] MAG_MASK =
		(NB >= MAG_W) ? {MAG_W{1'b1}} : MAG_W'((WIDE_W'(1) << NB) - WIDE_W'(1));
	localparam logic [SHIFT_W-1:0] ND_SHIFT = SHIFT_W'(DIGITS);

	logic [MAG_W-1:0] am;
	logic [MAG_W-1:0] bm;

	always_comb begin
		am = a_mag & MAG_MASK;
		bm = b_mag & MAG_MASK;
		op.func      = smh_func_t'(func);
		op.a_mag     = am;
		op.b_mag     = bm;
		// A zero magnitude always counts as plus zero.
		op.a_sign    = a_sign && (am != '0);
		op.b_sign    = b_sign && (bm != '0);
		op.b_nz      = (bm != '0);
		op.shift_cnt = (shift_amount > ND_SHIFT) ? CNT_W'(DIGITS) : shift_amount[CNT_W-1:0];
	end

endmodule

// ===== rtl/core/smh_exec.sv =====
// Second stage: adder, both subtractors, magnitude compare and the digit shifters.
`timescale 1ns / 1ps

module smh_exec #(
	parameter int DIGITS = 8
) (
	input  smh_pkg::smh_op_t  op,
	output smh_pkg::smh_exe_t exe
);
	import smh_pkg::*;

	localparam int NB = 4 * DIGITS;
	localparam logic [MAG_W:0] SUM_MASK =
		(NB > MAG_W) ? {(MAG_W + 1){1'b1}} : (MAG_W + 1)'((WIDE_W'(1) << NB) - WIDE_W'(1));
	localparam logic [WIDE_W-1:0] WIDE_MASK =
		(NB >= WIDE_W) ? {WIDE_W{1'b1}} : ((WIDE_W'(1) << NB) - WIDE_W'(1));
	localparam logic [CNT_W-1:0] ND_CNT = CNT_W'(DIGITS);

	logic [MAG_W:0]    sum_raw;
	logic [WIDE_W-1:0] shl_raw;
	logic [6:0]        bit_shift;
	logic              shift_out;

	always_comb begin
		sum_raw   = {1'b0, op.a_mag} + {1'b0, op.b_mag};
		bit_shift = {op.shift_cnt, 2'b00};
		shift_out = (op.shift_cnt >= ND_CNT);
		shl_raw   = {{(WIDE_W - MAG_W){1'b0}}, op.a_mag} << bit_shift;

		exe.func    = op.func;
		exe.a_sign  = op.a_sign;
		exe.b_sign  = op.b_sign;
		exe.b_nz    = op.b_nz;
		exe.a_odd   = op.a_mag[0];
		exe.sum     = sum_raw & SUM_MASK;
		// Carry out of the digit width is an overflow.
		exe.sum_ovf = |(sum_raw & ~SUM_MASK);
		exe.diff_ab = {1'b0, op.a_mag} - {1'b0, op.b_mag};
		exe.diff_ba = op.b_mag - op.a_mag;
		exe.mag_eq  = (op.a_mag == op.b_mag);
		exe.shl     = shift_out ? '0 : (shl_raw & WIDE_MASK);
		exe.shr     = shift_out ? '0 : (op.a_mag >> bit_shift);
	end

endmodule

// ===== rtl/core/smh_resolve.sv =====
// Third stage: picks the result by function code and forms sign and flag.
`timescale 1ns / 1ps

module smh_resolve (
	input  smh_pkg::smh_exe_t         exe,
	output logic                      result_sign,
	output logic [smh_pkg::MAG_W-1:0] result_mag,
	output logic                      flag
);
	import smh_pkg::*;

	logic           bs_eff;
	logic           mag_lt;
	logic           mag_gt;
	logic           a_gt_b;
	logic           b_gt_a;
	logic [MAG_W:0] rm;

	always_comb begin
		mag_lt = exe.diff_ab[MAG_W];
		mag_gt = !mag_lt && !exe.mag_eq;
		a_gt_b = (exe.a_sign != exe.b_sign) ? !exe.a_sign : (exe.a_sign ? mag_lt : mag_gt);
		b_gt_a = (exe.a_sign != exe.b_sign) ? !exe.b_sign : (exe.b_sign ? mag_gt : mag_lt);
		bs_eff = (exe.func == FN_SUB && exe.b_nz) ? !exe.b_sign : exe.b_sign;

		rm          = '0;
		result_sign = 1'b0;
		result_mag  = '0;
		flag        = 1'b0;

		case (exe.func)
			FN_ADD, FN_SUB: begin
				if (exe.a_sign == bs_eff) begin
					rm          = exe.sum;
					flag        = exe.sum_ovf;
					result_sign = exe.a_sign;
				end else if (!mag_lt) begin
					rm          = exe.diff_ab;
					result_sign = exe.a_sign;
				end else begin
					rm          = {1'b0, exe.diff_ba};
					result_sign = bs_eff;
				end
				// An overflowing sum is never truly zero, so it keeps its sign.
				if (rm == '0 && !flag) begin
					result_sign = 1'b0;
				end
				result_mag = rm[MAG_W-1:0];
			end
			FN_SHL: begin
				result_mag  = exe.shl[MAG_W-1:0];
				result_sign = exe.a_sign && (exe.shl != '0);
			end
			FN_SHR: begin
				result_mag  = exe.shr;
				result_sign = exe.a_sign && (exe.shr != '0);
			end
			FN_EQ:   flag = (exe.a_sign == exe.b_sign) && exe.mag_eq;
			FN_NE:   flag = !((exe.a_sign == exe.b_sign) && exe.mag_eq);
			FN_GT:   flag = a_gt_b;
			FN_LT:   flag = b_gt_a;
			FN_GE:   flag = !b_gt_a;
			FN_LE:   flag = !a_gt_b;
			FN_ODD:  flag = exe.a_odd;
			default: flag = 1'b0;
		endcase
	end

endmodule

// ===== rtl/core/sign_magnitude_hex_alu.sv =====
// Top level of the three-stage sign-magnitude hex ALU.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// A transaction enters when start is high at a rising clock edge and busy is low.
// The block never stalls, so busy is held low and a new transaction may enter in
// every cycle. The operands are sign and magnitude pairs of DIGITS hex digits;
// func selects add, subtract, digit shift left or right of operand a, one of six
// signed compares, or an odd test of a.
// A transaction passes through the normalize, arithmetic and output registers; its result
// is on result_sign, result_mag and flag while done is high for exactly one cycle, and
// it is taken at the rising edge that ends that cycle.
// Throughput is one transaction per cycle, set by the three register stages:
// normalize, arithmetic (adder, subtractors, shifters), and result select.
// The receiver cannot hold results off; each result is taken in its done cycle.
// Reset clears the valid bits of all stages, so nothing in flight survives it and
// done stays low until a new transaction has passed through. The data registers
// are not reset.
// Zero magnitudes count as plus zero; zero results are plus unless a sum overflowed.
module sign_magnitude_hex_alu #(
	parameter int DIGITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [smh_pkg::FUNC_W-1:0]  func,
	input  logic                        a_sign,
	input  logic [smh_pkg::MAG_W-1:0]   a_mag,
	input  logic                        b_sign,
	input  logic [smh_pkg::MAG_W-1:0]   b_mag,
	input  logic [smh_pkg::SHIFT_W-1:0] shift_amount,
	output logic                        done,
	output logic                        result_sign,
	output logic [smh_pkg::MAG_W-1:0]   result_mag,
	output logic                        flag
);
	import smh_pkg::*;

	smh_op_t          op_c;
	smh_op_t          op_s1;
	smh_exe_t         exe_c;
	smh_exe_t         exe_s2;
	logic             v_s1;
	logic             v_s2;
	logic             done_q;
	logic             res_sign_c;
	logic [MAG_W-1:0] res_mag_c;
	logic             flag_c;
	logic             result_sign_q;
	logic [MAG_W-1:0] result_mag_q;
	logic             flag_q;
	logic             cmp_s2;
	logic             shift_s2;

	// The pipeline has no back pressure, so it is always ready.
	assign busy = 1'b0;

	smh_norm #(.DIGITS(DIGITS)) u_norm (
		.func         (func),
		.a_sign       (a_sign),
		.a_mag        (a_mag),
		.b_sign       (b_sign),
		.b_mag        (b_mag),
		.shift_amount (shift_amount),
		.op           (op_c)
	);

	smh_exec #(.DIGITS(DIGITS)) u_exec (
		.op  (op_s1),
		.exe (exe_c)
	);

	smh_resolve u_resolve (
		.exe         (exe_s2),
		.result_sign (res_sign_c),
		.result_mag  (res_mag_c),
		.flag        (flag_c)
	);

	// Valid bits travel alongside the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// Data registers only load when their stage carries a transaction.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1 <= op_c;
		end
		if (v_s1) begin
			exe_s2 <= exe_c;
		end
		if (v_s2) begin
			result_sign_q <= res_sign_c;
			result_mag_q  <= res_mag_c;
			flag_q        <= flag_c;
		end
	end

	assign done        = done_q;
	assign result_sign = result_sign_q;
	assign result_mag  = result_mag_q;
	assign flag        = flag_q;

	assign cmp_s2 = exe_s2.func inside {FN_EQ, FN_NE, FN_GT, FN_LT, FN_GE, FN_LE, FN_ODD};
	assign shift_s2 = exe_s2.func inside {FN_SHL, FN_SHR};

	`SMH_ASSERT_NXT(a_enter_s1, clk, arst_n, start && !busy, v_s1)
	`SMH_ASSERT_NXT(a_s1_to_s2, clk, arst_n, v_s1, v_s2)
	`SMH_ASSERT_NXT(a_s2_to_out, clk, arst_n, v_s2, done)
	`SMH_ASSERT_IMP(a_cmp_no_mag, clk, arst_n, done && $past(cmp_s2), result_mag == '0 && !result_sign)
	`SMH_ASSERT_IMP(a_shift_no_flag, clk, arst_n, done && $past(shift_s2), !flag)

endmodule

// ===== tb/tb_sign_magnitude_hex_alu.sv =====
// Self-checking testbench for the sign-magnitude hex ALU.
`timescale 1ns / 1ps

module tb_sign_magnitude_hex_alu;
	import smh_pkg::*;

	localparam int DIGITS = 8;

	// Function codes past FN_ODD are unused; the block must answer them with all zeros.
	localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 4'd11;
	localparam logic [FUNC_W-1:0] FN_LAST_UNUSED  = 4'd15;

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// The pipeline is three stages deep; after the last result we watch a few more
	// cycles so that a stray result would still be caught.
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_OPS  = 1150;
	localparam int MAX_REPORTS = 10;

	// One transaction as offered to the block, with the idle cycles that precede it
	// and a flag that holds it back until every earlier result has come out.
	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic               a_sign;
		logic [MAG_W-1:0]   a_mag;
		logic               b_sign;
		logic [MAG_W-1:0]   b_mag;
		logic [SHIFT_W-1:0] shift_amount;
		int                 gap;
		bit                 drain;
	} alu_op_t;

	typedef struct {
		logic             sign;
		logic [MAG_W-1:0] mag;
		logic             flag;
	} alu_res_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [FUNC_W-1:0]    func = '0;
	logic                 a_sign = 1'b0;
	logic [MAG_W-1:0]     a_mag = '0;
	logic                 b_sign = 1'b0;
	logic [MAG_W-1:0]     b_mag = '0;
	logic [SHIFT_W-1:0]   shift_amount = '0;
	logic                 done;
	logic                 result_sign;
	logic [MAG_W-1:0]     result_mag;
	logic                 flag;

	alu_op_t  pending_ops[$];
	alu_res_t expected_results[$];
	alu_op_t  presented_op;
	int       idle_left = 0;
	int       ops_accepted = 0;
	int       results_checked = 0;
	int       fault_count = 0;
	int       ops_per_func[16];

	sign_magnitude_hex_alu #(
		.DIGITS(DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.a_sign(a_sign),
		.a_mag(a_mag),
		.b_sign(b_sign),
		.b_mag(b_mag),
		.shift_amount(shift_amount),
		.done(done),
		.result_sign(result_sign),
		.result_mag(result_mag),
		.flag(flag)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// True signed compare of two normalized sign-magnitude values: x > y.
	function automatic bit signed_greater(logic xs, logic [63:0] xm, logic ys, logic [63:0] ym);
		if (xs != ys)
			return xs == 1'b0;
		if (xs == 1'b0)
			return xm > ym;
		return xm < ym;
	endfunction

	// Computes what the ALU must return for one transaction. Magnitudes are widened to
	// 64 bits so that the carry out of an add is visible as overflow.
	function automatic alu_res_t predict_alu_result(alu_op_t op);
		logic [63:0] mask;
		logic [63:0] am;
		logic [63:0] bm;
		logic [63:0] sum;
		logic [63:0] rm;
		logic        as;
		logic        bs;
		logic        rs;
		logic        fl;
		int unsigned sh;
		alu_res_t    res;
		mask = (64'd1 << (4 * DIGITS)) - 64'd1;
		am = {32'b0, op.a_mag} & mask;
		bm = {32'b0, op.b_mag} & mask;
		// A zero magnitude is plus zero whatever its sign bit says.
		as = (am != 0) ? op.a_sign : 1'b0;
		bs = (bm != 0) ? op.b_sign : 1'b0;
		sh = (op.shift_amount > DIGITS) ? DIGITS : op.shift_amount;
		rs = 1'b0;
		fl = 1'b0;
		rm = '0;
		case (op.func)
			FN_ADD, FN_SUB: begin
				// Subtract is an add of b with its sign flipped, unless b is zero.
				if (op.func == FN_SUB && bm != 0)
					bs = ~bs;
				if (as == bs) begin
					sum = am + bm;
					fl = |(sum & ~mask);
					rm = sum & mask;
					rs = as;
				end else if (am >= bm) begin
					rm = am - bm;
					rs = as;
				end else begin
					rm = bm - am;
					rs = bs;
				end
				// An overflowed sum is not truly zero, so it keeps its sign.
				if (rm == 0 && !fl)
					rs = 1'b0;
			end
			FN_SHL: begin
				rm = (sh >= DIGITS) ? 64'd0 : ((am << (4 * sh)) & mask);
				rs = (rm != 0) ? as : 1'b0;
			end
			FN_SHR: begin
				rm = (sh >= DIGITS) ? 64'd0 : (am >> (4 * sh));
				rs = (rm != 0) ? as : 1'b0;
			end
			FN_EQ:  fl = (as == bs) && (am == bm);
			FN_NE:  fl = !((as == bs) && (am == bm));
			FN_GT:  fl = signed_greater(as, am, bs, bm);
			FN_LT:  fl = signed_greater(bs, bm, as, am);
			FN_GE:  fl = !signed_greater(bs, bm, as, am);
			FN_LE:  fl = !signed_greater(as, am, bs, bm);
			FN_ODD: fl = am[0];
			default: begin
			end
		endcase
		res.sign = rs;
		res.mag = rm[MAG_W-1:0];
		res.flag = fl;
		return res;
	endfunction

	function automatic alu_op_t make_op(logic [FUNC_W-1:0] f, logic as, logic [MAG_W-1:0] am,
			logic bs, logic [MAG_W-1:0] bm, logic [SHIFT_W-1:0] sh);
		alu_op_t op;
		op.func = f;
		op.a_sign = as;
		op.a_mag = am;
		op.b_sign = bs;
		op.b_mag = bm;
		op.shift_amount = sh;
		op.gap = 0;
		op.drain = 1'b0;
		return op;
	endfunction

	// Picks a magnitude, leaning toward the corners: zero, all ones, tiny values, a single
	// bit, and values equal to or next to the other operand so that compares and
	// subtracts land on their boundaries.
	function automatic logic [MAG_W-1:0] pick_mag(logic [MAG_W-1:0] other);
		case ($urandom_range(0, 11))
			0:       return '0;
			1:       return MAG_MAX;
			2:       return $urandom_range(0, 15);
			3:       return other;
			4:       return other + 1;
			5:       return other - 1;
			6:       return 32'd1 << $urandom_range(0, MAG_W - 1);
			7:       return MAG_MAX - $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	// Mostly zero-length gaps, some short, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Prints the first few faults in full; after that they are only counted.
	task automatic report_fault(string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Stimulus: a directed opening that visits the corners of every function, then a
	// long random stretch.
	initial begin
		alu_op_t         op;
		logic [MAG_W-1:0] am;
		int              fcode;
		// Add: largest positive sum overflows, keeping the plus sign.
		pending_ops.push_back(make_op(FN_ADD, 1'b0, MAG_MAX, 1'b0, MAG_MAX, 6'd0));
		// Add: negative overflow keeps the minus sign.
		pending_ops.push_back(make_op(FN_ADD, 1'b1, MAG_MAX, 1'b1, 32'd1, 6'd0));
		// Add: opposite values cancel to plus zero.
		pending_ops.push_back(make_op(FN_ADD, 1'b0, 32'd5, 1'b1, 32'd5, 6'd0));
		// Subtract of two zeros, both carrying a minus sign.
		pending_ops.push_back(make_op(FN_SUB, 1'b1, 32'd0, 1'b1, 32'd0, 6'd0));
		// Subtract from a negative zero.
		pending_ops.push_back(make_op(FN_SUB, 1'b1, 32'd0, 1'b0, 32'd7, 6'd0));
		// Subtract that crosses zero.
		pending_ops.push_back(make_op(FN_SUB, 1'b0, 32'd3, 1'b0, 32'd5, 6'd0));
		// Subtract of a negative number from the largest positive one overflows.
		pending_ops.push_back(make_op(FN_SUB, 1'b0, MAG_MAX, 1'b1, MAG_MAX, 6'd0));
		// Shifts: no shift, a shift of all digits, a count far above the clamp, and a
		// negative operand shifted to zero, which must come out as plus zero.
		pending_ops.push_back(make_op(FN_SHL, 1'b1, 32'h1234_5678, 1'b0, 32'd0, 6'd0));
		pending_ops.push_back(make_op(FN_SHL, 1'b0, MAG_MAX, 1'b0, 32'd0, 6'd8));
		pending_ops.push_back(make_op(FN_SHL, 1'b1, MAG_MAX, 1'b0, 32'd0, 6'd63));
		pending_ops.push_back(make_op(FN_SHL, 1'b1, 32'h1000_0000, 1'b0, 32'd0, 6'd1));
		pending_ops.push_back(make_op(FN_SHR, 1'b1, MAG_MAX, 1'b1, MAG_MAX, 6'd7));
		pending_ops.push_back(make_op(FN_SHR, 1'b1, 32'h0000_000F, 1'b0, 32'd0, 6'd1));
		pending_ops.push_back(make_op(FN_SHR, 1'b0, MAG_MAX, 1'b0, 32'd0, 6'd40));
		// Compares: plus zero equals minus zero; both-negative ordering; equal values.
		pending_ops.push_back(make_op(FN_EQ, 1'b0, 32'd0, 1'b1, 32'd0, 6'd0));
		pending_ops.push_back(make_op(FN_NE, 1'b1, MAG_MAX, 1'b0, MAG_MAX, 6'd0));
		pending_ops.push_back(make_op(FN_GT, 1'b1, 32'd2, 1'b1, 32'd9, 6'd0));
		pending_ops.push_back(make_op(FN_LT, 1'b1, 32'd2, 1'b1, 32'd9, 6'd0));
		pending_ops.push_back(make_op(FN_GE, 1'b1, 32'd0, 1'b0, 32'd0, 6'd0));
		pending_ops.push_back(make_op(FN_LE, 1'b0, MAG_MAX, 1'b1, MAG_MAX, 6'd0));
		pending_ops.push_back(make_op(FN_GT, 1'b0, 32'd0, 1'b1, 32'd1, 6'd0));
		pending_ops.push_back(make_op(FN_ODD, 1'b1, MAG_MAX, 1'b0, 32'd0, 6'd0));
		pending_ops.push_back(make_op(FN_ODD, 1'b0, 32'hFFFF_FFFE, 1'b1, MAG_MAX, 6'd0));
		// Unused function codes must give an all-zero result.
		pending_ops.push_back(make_op(FN_FIRST_UNUSED, 1'b1, MAG_MAX, 1'b1, MAG_MAX, 6'd3));
		pending_ops.push_back(make_op(FN_LAST_UNUSED, 1'b1, MAG_MAX, 1'b0, 32'd1, 6'd63));

		for (int i = 0; i < RANDOM_OPS; i++) begin
			if ($urandom_range(0, 19) == 0)
				fcode = $urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED);
			else
				fcode = $urandom_range(FN_ADD, FN_ODD);
			am = pick_mag($urandom);
			op = make_op(FUNC_W'(fcode), 1'($urandom_range(0, 1)), am,
				1'($urandom_range(0, 1)), pick_mag(am),
				SHIFT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, 9)));
			// Every third block of 64 transactions runs back to back with no gaps.
			op.gap = ((i / 64) % 3 == 1) ? 0 : pick_gap();
			// Now and then the sender waits for the pipeline to empty completely.
			op.drain = (i % 250 == 125);
			pending_ops.push_back(op);
		end
	end

	// Reset starts asserted and is released at a falling edge, away from the rising edge.
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver. At each edge it first books the transaction that the edge accepted, then
	// decides what to present for the next cycle. Each port gets exactly one nonblocking
	// assignment per edge, so start stays high across back-to-back transactions.
	always @(posedge clk or negedge arst_n) begin
		bit present;
		if (!arst_n) begin
			start <= 1'b0;
			func <= '0;
			a_sign <= 1'b0;
			a_mag <= '0;
			b_sign <= 1'b0;
			b_mag <= '0;
			shift_amount <= '0;
			idle_left = 0;
		end else begin
			present = 1'b0;
			if (start && !busy) begin
				expected_results.push_back(predict_alu_result(presented_op));
				ops_per_func[presented_op.func]++;
				ops_accepted++;
			end
			if (start && busy) begin
				// Not taken yet: hold the transaction on the ports.
				present = 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
			end else if (pending_ops.size() != 0) begin
				// A draining transaction waits until nothing is outstanding. Testing done
				// as well keeps this decision independent of whether the monitor has
				// already retired this edge's result.
				if (!pending_ops[0].drain || (expected_results.size() == 0 && !done)) begin
					presented_op = pending_ops.pop_front();
					present = 1'b1;
					idle_left = (pending_ops.size() != 0) ? pending_ops[0].gap : 0;
				end
			end
			start <= present;
			if (present) begin
				func <= presented_op.func;
				a_sign <= presented_op.a_sign;
				a_mag <= presented_op.a_mag;
				b_sign <= presented_op.b_sign;
				b_mag <= presented_op.b_mag;
				shift_amount <= presented_op.shift_amount;
			end else begin
				// While idle the operand ports carry noise that the block must ignore.
				func <= FUNC_W'($urandom_range(0, 15));
				a_sign <= 1'($urandom_range(0, 1));
				a_mag <= $urandom;
				b_sign <= 1'($urandom_range(0, 1));
				b_mag <= $urandom;
				shift_amount <= SHIFT_W'($urandom_range(0, 63));
			end
		end
	end

	// Monitor. A result is valid for the single cycle in which done is high, so it is
	// sampled at the edge that closes that cycle and matched to the oldest expectation.
	always @(posedge clk) begin
		alu_res_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				report_fault($sformatf("result with no transaction outstanding: sign=%0b mag=%h flag=%0b",
					result_sign, result_mag, flag));
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result_sign !== want.sign)
					report_fault($sformatf("result %0d result_sign: expected %0b, got %0b",
						results_checked, want.sign, result_sign));
				if (result_mag !== want.mag)
					report_fault($sformatf("result %0d result_mag: expected %h, got %h",
						results_checked, want.mag, result_mag));
				if (flag !== want.flag)
					report_fault($sformatf("result %0d flag: expected %0b, got %0b",
						results_checked, want.flag, flag));
			end
		end
	end

	// End of run: once every transaction has been taken and every result has come out,
	// a few more cycles pass so that any extra result is caught.
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		while (pending_ops.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d transactions (%0d add, %0d sub, %0d shift, %0d compare, %0d odd,",
			ops_accepted, ops_per_func[FN_ADD], ops_per_func[FN_SUB],
			ops_per_func[FN_SHL] + ops_per_func[FN_SHR],
			ops_per_func[FN_EQ] + ops_per_func[FN_NE] + ops_per_func[FN_GT]
				+ ops_per_func[FN_LT] + ops_per_func[FN_GE] + ops_per_func[FN_LE],
			ops_per_func[FN_ODD]);
		$display("%0d with unused codes); %0d results checked, %0d faults found.",
			ops_accepted - ops_per_func[FN_ADD] - ops_per_func[FN_SUB] - ops_per_func[FN_SHL]
				- ops_per_func[FN_SHR] - ops_per_func[FN_EQ] - ops_per_func[FN_NE]
				- ops_per_func[FN_GT] - ops_per_func[FN_LT] - ops_per_func[FN_GE]
				- ops_per_func[FN_LE] - ops_per_func[FN_ODD],
			results_checked, fault_count);
		if (fault_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog. The slowest correct run, with every gap at its longest and every drain
	// pause, stays well below this.
	initial begin
		#2_000_000;
		$display("Timeout with %0d results still outstanding.", expected_results.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/smh_pkg.sv
rtl/core/smh_norm.sv
rtl/core/smh_exec.sv
rtl/core/smh_resolve.sv
rtl/core/sign_magnitude_hex_alu.sv
tb/tb_sign_magnitude_hex_alu.sv
